### src/dtsc_pkg.sv
// Shared types and constants for the differential thruster servo command block.
package dtsc_pkg;

   // Field widths
   localparam int OP_W      = 3;
   localparam int JOY_W     = 8;
   localparam int DIGI_W    = 8;
   localparam int TICK_W    = 16;
   localparam int DEADBAND_W = 7;
   localparam int SPAN_W    = 15;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Mixed command (turn - fwd or fwd + turn), magnitude after clamp, span product
   localparam int CMD_W  = 10;
   localparam int MAG_W  = 7;
   localparam int PROD_W = MAG_W + SPAN_W;

   localparam logic [MAG_W-1:0]        CMD_LIMIT   = 7'd127;
   // fwd + turn carries two joystick centers of 127
   localparam logic signed [CMD_W-1:0] JOY_MID_SUM = 10'sd254;

   // x / 127 == (x * RECIP_MULT) >> RECIP_SHIFT, exact for x < 2^22
   localparam int                    RECIP_W     = 23;
   localparam int                    RECIP_SHIFT = 29;
   localparam logic [RECIP_W-1:0]    RECIP_MULT  = 23'd4227331;
   localparam int                    RECIP_PROD_W = PROD_W + RECIP_W;

   // Register reset values
   localparam logic [DEADBAND_W-1:0] DEADBAND_RST  = 7'd5;
   localparam logic [SPAN_W-1:0]     HALF_SPAN_RST = 15'd625;
   localparam logic [TICK_W-1:0]     NEUTRAL_RST   = 16'd3750;
   localparam logic [TICK_W-1:0]     REST_RST      = 16'd2500;
   localparam logic [TICK_W-1:0]     ACTIVE_RST    = 16'd5000;
   localparam logic [TICK_W-1:0]     PAIRED_RST    = 16'd2050;
   localparam logic [TICK_W-1:0]     UNPAIRED_RST  = 16'd3750;

   typedef enum logic [OP_W-1:0] {
      OP_THRUST  = 3'd0,
      OP_DIGITAL = 3'd1,
      OP_STOP    = 3'd2,
      OP_PAIR    = 3'd3,
      OP_NOP     = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEADBAND  = 3'd0,
      REG_HALF_SPAN = 3'd1,
      REG_NEUTRAL   = 3'd2,
      REG_REST      = 3'd3,
      REG_ACTIVE    = 3'd4,
      REG_PAIRED    = 3'd5,
      REG_UNPAIRED  = 3'd6
   } csr_idx_type;

   // One thruster lane between the product stage and the divide stage
   typedef struct packed {
      logic              in_band;
      logic              neg;
      logic [PROD_W-1:0] prod;
   } lane_type;

endpackage

### src/differential_thruster_servo_command.sv
// Differential thruster mixer and servo pulse-width setpoint holder (top level).
// Pipeline: the input, product and setpoint registers lie between the accepting edge and rsp_valid.
// Throughput: one transaction per cycle while rsp_ready keeps up; bubbles collapse under output backpressure.
// Reset: synchronous, active high; setpoints and registers return to their defaults.
// Config writes take effect on the next transaction that uses them.
module differential_thruster_servo_command (
   input  logic                              clock,
   input  logic                              reset,
   // command transactions
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dtsc_pkg::OP_W-1:0]         req_operation,
   input  logic [dtsc_pkg::JOY_W-1:0]        req_joy_forward,
   input  logic [dtsc_pkg::JOY_W-1:0]        req_joy_turn,
   input  logic [dtsc_pkg::DIGI_W-1:0]       req_digi_bits,
   input  logic                              req_paired,
   // setpoint transactions
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dtsc_pkg::TICK_W-1:0]       rsp_left_pulse,
   output logic [dtsc_pkg::TICK_W-1:0]       rsp_right_pulse,
   output logic [dtsc_pkg::TICK_W-1:0]       rsp_gate_pulse,
   output logic [dtsc_pkg::TICK_W-1:0]       rsp_indicator_pulse,
   output logic [dtsc_pkg::TICK_W-1:0]       rsp_smacker_pulse,
   // config write port
   input  logic                              csr_write_en,
   input  logic [dtsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dtsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dtsc_pkg::*;

   // Clamp a mixed command to +/-127 and return its magnitude
   function automatic logic [MAG_W-1:0] cmd_mag(input logic signed [CMD_W-1:0] c);
      logic signed [CMD_W-1:0] a;
      a = c[CMD_W-1] ? -c : c;
      if (a > $signed({{(CMD_W-MAG_W){1'b0}}, CMD_LIMIT}))
         return CMD_LIMIT;
      else
         return a[MAG_W-1:0];
   endfunction

   // Divide the span product by 127 (toward zero), apply sign, add neutral, saturate
   function automatic logic [TICK_W-1:0] lane_width(input lane_type l,
                                                    input logic [TICK_W-1:0] neutral);
      logic [RECIP_PROD_W-1:0] full;
      logic [SPAN_W-1:0]       q;
      logic [TICK_W:0]         sum;
      full = {{RECIP_W{1'b0}}, l.prod} * {{PROD_W{1'b0}}, RECIP_MULT};
      q    = full[RECIP_SHIFT+SPAN_W-1:RECIP_SHIFT];
      if (l.in_band)
         return neutral;
      else if (l.neg) begin
         if ({1'b0, q} > neutral)
            return '0;
         else
            return neutral - {1'b0, q};
      end else begin
         sum = {1'b0, neutral} + {2'b00, q};
         if (sum[TICK_W])
            return '1;
         else
            return sum[TICK_W-1:0];
      end
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DEADBAND_W-1:0] deadband_ff;
   logic [SPAN_W-1:0]     half_span_ff;
   logic [TICK_W-1:0]     neutral_ff;
   logic [TICK_W-1:0]     rest_ff;
   logic [TICK_W-1:0]     active_ff;
   logic [TICK_W-1:0]     paired_ff;
   logic [TICK_W-1:0]     unpaired_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= DEADBAND_RST;
         half_span_ff <= HALF_SPAN_RST;
         neutral_ff   <= NEUTRAL_RST;
         rest_ff      <= REST_RST;
         active_ff    <= ACTIVE_RST;
         paired_ff    <= PAIRED_RST;
         unpaired_ff  <= UNPAIRED_RST;
      end else if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            REG_DEADBAND:  deadband_ff  <= csr_wdata[DEADBAND_W-1:0];
            REG_HALF_SPAN: half_span_ff <= csr_wdata[SPAN_W-1:0];
            REG_NEUTRAL:   neutral_ff   <= csr_wdata[TICK_W-1:0];
            REG_REST:      rest_ff      <= csr_wdata[TICK_W-1:0];
            REG_ACTIVE:    active_ff    <= csr_wdata[TICK_W-1:0];
            REG_PAIRED:    paired_ff    <= csr_wdata[TICK_W-1:0];
            REG_UNPAIRED:  unpaired_ff  <= csr_wdata[TICK_W-1:0];
            default: ;     // unmapped index: write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: each stage loads when empty or when its
   // successor frees up, so bubbles are squeezed out under stalls.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_ready, s2_ready, s1_ready;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_valid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (out_ready) rsp_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: input register
   // ---------------------------------------------------------------------
   op_type           s1_op_ff;
   logic [JOY_W-1:0] s1_fwd_ff, s1_turn_ff;
   logic [1:0]       s1_digi_ff;
   logic             s1_paired_ff;

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_op_ff     <= op_type'(req_operation);
         s1_fwd_ff    <= req_joy_forward;
         s1_turn_ff   <= req_joy_turn;
         s1_digi_ff   <= req_digi_bits[1:0];
         s1_paired_ff <= req_paired;
      end
   end

   // Mix: the joystick centers cancel in turn - fwd; fwd + turn carries both.
   logic signed [CMD_W-1:0] cmd_left, cmd_right;
   logic [MAG_W-1:0]        mag_left, mag_right;
   lane_type                lane_left_in, lane_right_in;

   always_comb begin
      cmd_left  = $signed({2'b00, s1_turn_ff}) - $signed({2'b00, s1_fwd_ff});
      cmd_right = $signed({2'b00, s1_fwd_ff}) + $signed({2'b00, s1_turn_ff}) - JOY_MID_SUM;
      mag_left  = cmd_mag(cmd_left);
      mag_right = cmd_mag(cmd_right);

      // |c| < deadband is the open band -deadband < c < deadband
      lane_left_in.in_band  = mag_left < deadband_ff;
      lane_left_in.neg      = cmd_left[CMD_W-1];
      lane_left_in.prod     = {{SPAN_W{1'b0}}, mag_left} * {{MAG_W{1'b0}}, half_span_ff};
      lane_right_in.in_band = mag_right < deadband_ff;
      lane_right_in.neg     = cmd_right[CMD_W-1];
      lane_right_in.prod    = {{SPAN_W{1'b0}}, mag_right} * {{MAG_W{1'b0}}, half_span_ff};
   end

   // ---------------------------------------------------------------------
   // Stage 2: span products registered
   // ---------------------------------------------------------------------
   op_type     s2_op_ff;
   lane_type   s2_left_ff, s2_right_ff;
   logic [1:0] s2_digi_ff;
   logic       s2_paired_ff;

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_op_ff     <= s1_op_ff;
         s2_left_ff   <= lane_left_in;
         s2_right_ff  <= lane_right_in;
         s2_digi_ff   <= s1_digi_ff;
         s2_paired_ff <= s1_paired_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: setpoint registers, which are also the response payload.
   // They only change when a transaction moves in, so a stalled response
   // holds steady.
   // ---------------------------------------------------------------------
   logic [TICK_W-1:0] left_width_ff, right_width_ff, gate_width_ff;
   logic [TICK_W-1:0] indicator_width_ff, smacker_width_ff;
   logic [TICK_W-1:0] left_width_in, right_width_in, gate_width_in;
   logic [TICK_W-1:0] indicator_width_in, smacker_width_in;
   logic              load_out;

   assign load_out = out_ready && s2_valid_ff;

   always_comb begin
      left_width_in      = left_width_ff;
      right_width_in     = right_width_ff;
      gate_width_in      = gate_width_ff;
      indicator_width_in = indicator_width_ff;
      smacker_width_in   = smacker_width_ff;
      unique case (s2_op_ff)
         OP_THRUST: begin
            left_width_in  = lane_width(s2_left_ff, neutral_ff);
            right_width_in = lane_width(s2_right_ff, neutral_ff);
         end
         OP_DIGITAL: begin
            gate_width_in    = s2_digi_ff[0] ? active_ff : rest_ff;
            smacker_width_in = s2_digi_ff[1] ? active_ff : rest_ff;
         end
         OP_STOP: begin
            // indicator is left alone
            left_width_in    = neutral_ff;
            right_width_in   = neutral_ff;
            gate_width_in    = rest_ff;
            smacker_width_in = rest_ff;
         end
         OP_PAIR: begin
            indicator_width_in = s2_paired_ff ? paired_ff : unpaired_ff;
         end
         default: ;   // no change, current setpoints still reported
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_width_ff      <= NEUTRAL_RST;
         right_width_ff     <= NEUTRAL_RST;
         gate_width_ff      <= REST_RST;
         indicator_width_ff <= UNPAIRED_RST;
         smacker_width_ff   <= REST_RST;
      end else if (load_out) begin
         left_width_ff      <= left_width_in;
         right_width_ff     <= right_width_in;
         gate_width_ff      <= gate_width_in;
         indicator_width_ff <= indicator_width_in;
         smacker_width_ff   <= smacker_width_in;
      end
   end

   assign rsp_left_pulse      = left_width_ff;
   assign rsp_right_pulse     = right_width_ff;
   assign rsp_gate_pulse      = gate_width_ff;
   assign rsp_indicator_pulse = indicator_width_ff;
   assign rsp_smacker_pulse   = smacker_width_ff;

endmodule

### bench/differential_thruster_servo_command_tb.sv
// Self-checking testbench for the differential thruster servo command block.
module differential_thruster_servo_command_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dtsc_pkg::*;

   // Codes the package leaves unnamed: reserved operations and the unused register slot
   localparam logic [OP_W-1:0]      OP_RESERVED_LO = 3'd5;
   localparam logic [OP_W-1:0]      OP_RESERVED_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED     = 3'd7;

   localparam int AXIS_MID     = 127;
   localparam int CMD_MAX      = 127;
   localparam int TICK_MAX     = 65535;
   localparam int SETTLE_CYCLES = 8;     // pipeline is 3 deep; margin on top
   localparam int HOLD_CYCLES  = 300;    // long output stall to fill the pipe

   // One command transaction as the sender presents it
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [JOY_W-1:0]  fwd;
      logic [JOY_W-1:0]  turn;
      logic [DIGI_W-1:0] digi;
      logic              pair;
   } command_type;

   // The five setpoints carried by one result transaction
   typedef struct packed {
      logic [TICK_W-1:0] left;
      logic [TICK_W-1:0] right;
      logic [TICK_W-1:0] gate;
      logic [TICK_W-1:0] indicator;
      logic [TICK_W-1:0] smacker;
   } pulse_set_type;

   // Every DUT input has a known value from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_operation = '0;
   logic [JOY_W-1:0]      req_joy_forward = '0;
   logic [JOY_W-1:0]      req_joy_turn = '0;
   logic [DIGI_W-1:0]     req_digi_bits = '0;
   logic                  req_paired = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [TICK_W-1:0]     rsp_left_pulse;
   logic [TICK_W-1:0]     rsp_right_pulse;
   logic [TICK_W-1:0]     rsp_gate_pulse;
   logic [TICK_W-1:0]     rsp_indicator_pulse;
   logic [TICK_W-1:0]     rsp_smacker_pulse;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow copy of the registers, at their reset values
   logic [DEADBAND_W-1:0] cfg_deadband  = DEADBAND_RST;
   logic [SPAN_W-1:0]     cfg_half_span = HALF_SPAN_RST;
   logic [TICK_W-1:0]     cfg_neutral   = NEUTRAL_RST;
   logic [TICK_W-1:0]     cfg_rest      = REST_RST;
   logic [TICK_W-1:0]     cfg_active    = ACTIVE_RST;
   logic [TICK_W-1:0]     cfg_paired    = PAIRED_RST;
   logic [TICK_W-1:0]     cfg_unpaired  = UNPAIRED_RST;

   // Predicted setpoints; reset puts thrusters at neutral, servos at rest, indicator unpaired
   pulse_set_type setpoints = '{NEUTRAL_RST, NEUTRAL_RST, REST_RST, UNPAIRED_RST, REST_RST};

   // Setpoint transactions predicted but not yet seen on the output
   pulse_set_type pending_setpoints[$];

   int errors         = 0;
   int commands_sent  = 0;
   int results_seen   = 0;
   int register_writes = 0;
   int settings_used  = 1;

   // Idle percentages for each side, changed by the tests
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Long stall request: the test bumps hold_seq, the receiver notices and counts
   int hold_seq = 0;

   differential_thruster_servo_command i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_joy_forward     (req_joy_forward),
      .req_joy_turn        (req_joy_turn),
      .req_digi_bits       (req_digi_bits),
      .req_paired          (req_paired),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_pulse      (rsp_left_pulse),
      .rsp_right_pulse     (rsp_right_pulse),
      .rsp_gate_pulse      (rsp_gate_pulse),
      .rsp_indicator_pulse (rsp_indicator_pulse),
      .rsp_smacker_pulse   (rsp_smacker_pulse),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   // Mixed command -> thruster pulse width: clamp, deadband, scale, saturate
   function automatic logic [TICK_W-1:0] thruster_width(int cmd);
      int band;
      int sum;
      band = int'(cfg_deadband);
      if (cmd > CMD_MAX) cmd = CMD_MAX;
      if (cmd < -CMD_MAX) cmd = -CMD_MAX;
      // strictly inside the band -> neutral; a zero band lets 0 fall through the formula
      if (cmd > -band && cmd < band) return cfg_neutral;
      // SV integer divide truncates toward zero
      sum = int'(cfg_neutral) + (cmd * int'(cfg_half_span)) / CMD_MAX;
      if (sum < 0) sum = 0;
      if (sum > TICK_MAX) sum = TICK_MAX;
      return sum[TICK_W-1:0];
   endfunction

   // Apply one command to the predicted setpoints and return what the block must emit
   function automatic pulse_set_type next_setpoints(command_type c);
      int fwd;
      int turn;
      fwd  = int'(c.fwd) - AXIS_MID;
      turn = int'(c.turn) - AXIS_MID;
      case (c.op)
         OP_THRUST: begin
            setpoints.left  = thruster_width(turn - fwd);
            setpoints.right = thruster_width(fwd + turn);
         end
         OP_DIGITAL: begin
            // only the low two bits matter
            setpoints.gate    = c.digi[0] ? cfg_active : cfg_rest;
            setpoints.smacker = c.digi[1] ? cfg_active : cfg_rest;
         end
         OP_STOP: begin
            // indicator deliberately left alone
            setpoints.left    = cfg_neutral;
            setpoints.right   = cfg_neutral;
            setpoints.gate    = cfg_rest;
            setpoints.smacker = cfg_rest;
         end
         OP_PAIR: begin
            setpoints.indicator = c.pair ? cfg_paired : cfg_unpaired;
         end
         default: begin
            // no-op and reserved codes: setpoints re-emitted unchanged
         end
      endcase
      return setpoints;
   endfunction

   // ---------------------------------------------------------------
   // Output side: receiver readiness and result checking
   // ---------------------------------------------------------------

   // rsp_ready changes on the falling edge; random idling or a counted long stall
   always @(negedge clock) begin : setpoint_receiver
      int hold_seen;
      int hold_left;
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic void check_field(string name, logic [TICK_W-1:0] want,
                                       logic [TICK_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   // Each accepted result transaction against the oldest prediction
   always @(posedge clock) begin : setpoint_checker
      pulse_set_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_setpoints.size() == 0) begin
            $error("setpoint transaction with no prediction pending");
            errors++;
         end else begin
            want = pending_setpoints.pop_front();
            check_field("left_pulse",      want.left,      rsp_left_pulse);
            check_field("right_pulse",     want.right,     rsp_right_pulse);
            check_field("gate_pulse",      want.gate,      rsp_gate_pulse);
            check_field("indicator_pulse", want.indicator, rsp_indicator_pulse);
            check_field("smacker_pulse",   want.smacker,   rsp_smacker_pulse);
         end
      end
   end

   // ---------------------------------------------------------------
   // Input side: command sender and register writes
   // ---------------------------------------------------------------

   function automatic command_type make_command(logic [OP_W-1:0] op, logic [JOY_W-1:0] fwd,
                                                logic [JOY_W-1:0] turn,
                                                logic [DIGI_W-1:0] digi, logic pair);
      command_type c;
      c.op   = op;
      c.fwd  = fwd;
      c.turn = turn;
      c.digi = digi;
      c.pair = pair;
      return c;
   endfunction

   // Joystick byte: half the time near center or at the rails, where the mapping is interesting, else random
   function automatic logic [JOY_W-1:0] random_axis();
      case ($urandom_range(3))
         0: return JOY_W'(AXIS_MID - 10 + $urandom_range(20));
         1: return $urandom_range(1) ? {JOY_W{1'b1}} : {JOY_W{1'b0}};
         default: return JOY_W'($urandom);
      endcase
   endfunction

   // Random command; don't-care fields stay random so every bit toggles
   function automatic command_type random_command();
      command_type c;
      int pick;
      pick = $urandom_range(99);
      if (pick < 45)      c.op = OP_THRUST;
      else if (pick < 60) c.op = OP_DIGITAL;
      else if (pick < 70) c.op = OP_STOP;
      else if (pick < 85) c.op = OP_PAIR;
      else if (pick < 93) c.op = OP_NOP;
      else                c.op = OP_W'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO));
      c.fwd  = random_axis();
      c.turn = random_axis();
      c.digi = DIGI_W'($urandom);
      c.pair = 1'($urandom);
      return c;
   endfunction

   // Offer one transaction from the falling edge, hold it until accepted, then predict.
   // Valid is left high on return; the next call or stop_commands drives it next.
   task automatic send_command(command_type c);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= c.op;
      req_joy_forward <= c.fwd;
      req_joy_turn    <= c.turn;
      req_digi_bits   <= c.digi;
      req_paired      <= c.pair;
      do @(posedge clock); while (!req_ready);
      commands_sent++;
      pending_setpoints.push_back(next_setpoints(c));
   endtask

   task automatic send_random(int count);
      repeat (count) send_command(random_command());
   endtask

   // Sender goes quiet and waits for every prediction to be met, then lets the pipe settle
   task automatic stop_commands();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_setpoints.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; junk above the register's width must be dropped by the block
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] keep;
      logic [CSR_DATA_W-1:0] junk;
      case (idx)
         REG_DEADBAND:  keep = CSR_DATA_W'({DEADBAND_W{1'b1}});
         REG_HALF_SPAN: keep = CSR_DATA_W'({SPAN_W{1'b1}});
         REG_NEUTRAL, REG_REST, REG_ACTIVE, REG_PAIRED, REG_UNPAIRED:
            keep = {CSR_DATA_W{1'b1}};
         default:       keep = '0;
      endcase
      junk = CSR_DATA_W'($urandom);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= (value & keep) | (junk & ~keep);
      @(posedge clock);
      register_writes++;
      case (idx)
         REG_DEADBAND:  cfg_deadband  = value[DEADBAND_W-1:0];
         REG_HALF_SPAN: cfg_half_span = value[SPAN_W-1:0];
         REG_NEUTRAL:   cfg_neutral   = value;
         REG_REST:      cfg_rest      = value;
         REG_ACTIVE:    cfg_active    = value;
         REG_PAIRED:    cfg_paired    = value;
         REG_UNPAIRED:  cfg_unpaired  = value;
         default: ;     // unused slot: ignored
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Full register setting, written only with the block drained; also pokes the unused slot
   task automatic apply_settings(int band, int span, int neutral, int rest, int active,
                                 int paired, int unpaired);
      stop_commands();
      write_register(REG_DEADBAND,  CSR_DATA_W'(band));
      write_register(REG_HALF_SPAN, CSR_DATA_W'(span));
      write_register(REG_NEUTRAL,   CSR_DATA_W'(neutral));
      write_register(REG_REST,      CSR_DATA_W'(rest));
      write_register(REG_ACTIVE,    CSR_DATA_W'(active));
      write_register(REG_PAIRED,    CSR_DATA_W'(paired));
      write_register(REG_UNPAIRED,  CSR_DATA_W'(unpaired));
      write_register(REG_UNUSED,    CSR_DATA_W'($urandom));
      settings_used++;
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Setpoints straight out of reset, re-emitted by a no-op
   task automatic test_reset_values();
      send_command(make_command(OP_NOP, 8'h00, 8'hFF, 8'hFF, 1'b1));
      send_command(make_command(OP_NOP, 8'hFF, 8'h00, 8'h00, 1'b0));
   endtask

   // Joystick rails, deadband edges, every named operation but the no-op, two reserved codes, with the reset settings
   task automatic test_directed_cases();
      send_command(make_command(OP_THRUST, 8'd127, 8'd127, 8'h00, 1'b0));  // centered
      send_command(make_command(OP_THRUST, 8'd255, 8'd127, 8'h00, 1'b0));  // full fwd
      send_command(make_command(OP_THRUST, 8'd0,   8'd127, 8'h00, 1'b0));  // full back
      send_command(make_command(OP_THRUST, 8'd127, 8'd255, 8'h00, 1'b0));  // full right
      send_command(make_command(OP_THRUST, 8'd127, 8'd0,   8'h00, 1'b0));  // full left
      send_command(make_command(OP_THRUST, 8'd255, 8'd255, 8'h00, 1'b0));  // right clamps
      send_command(make_command(OP_THRUST, 8'd0,   8'd0,   8'h00, 1'b0));  // right clamps low
      send_command(make_command(OP_THRUST, 8'd255, 8'd0,   8'h00, 1'b0));  // left far past limit
      send_command(make_command(OP_THRUST, 8'd0,   8'd255, 8'h00, 1'b0));
      send_command(make_command(OP_THRUST, 8'd132, 8'd127, 8'h00, 1'b0));  // on band edge
      send_command(make_command(OP_THRUST, 8'd131, 8'd127, 8'h00, 1'b0));  // just inside
      send_command(make_command(OP_THRUST, 8'd123, 8'd127, 8'h00, 1'b0));
      send_command(make_command(OP_DIGITAL, 8'h00, 8'h00, 8'h01, 1'b0));   // gate only
      send_command(make_command(OP_DIGITAL, 8'h00, 8'h00, 8'h02, 1'b0));   // smacker only
      send_command(make_command(OP_DIGITAL, 8'h00, 8'h00, 8'h03, 1'b0));   // both
      send_command(make_command(OP_DIGITAL, 8'h00, 8'h00, 8'hFC, 1'b0));   // upper bits ignored
      send_command(make_command(OP_DIGITAL, 8'h00, 8'h00, 8'hFF, 1'b0));
      send_command(make_command(OP_PAIR, 8'h00, 8'h00, 8'h00, 1'b1));
      send_command(make_command(OP_PAIR, 8'h00, 8'h00, 8'h00, 1'b0));
      send_command(make_command(OP_PAIR, 8'h00, 8'h00, 8'h00, 1'b1));
      send_command(make_command(OP_STOP, 8'hFF, 8'hFF, 8'hFF, 1'b0));     // indicator stays
      send_command(make_command(OP_RESERVED_LO, 8'h00, 8'h00, 8'h03, 1'b0));
      send_command(make_command(OP_RESERVED_HI, 8'hFF, 8'hFF, 8'hFF, 1'b1));
   endtask

   // Several register settings, extremes among them, each followed by traffic
   task automatic test_register_settings();
      // zero band: centered stick maps through the formula; neutral at the top rail saturates
      apply_settings(0, 32767, 65535, 0, 65535, 0, 65535);
      send_command(make_command(OP_THRUST, 8'd127, 8'd127, 8'h00, 1'b0));
      send_command(make_command(OP_THRUST, 8'd128, 8'd127, 8'h00, 1'b0));
      send_command(make_command(OP_THRUST, 8'd255, 8'd127, 8'h00, 1'b0));
      send_random(40);
      // widest band: only the rails escape; zero span and zero neutral
      apply_settings(127, 0, 0, 65535, 0, 65535, 0);
      send_command(make_command(OP_THRUST, 8'd255, 8'd127, 8'h00, 1'b0));
      send_command(make_command(OP_THRUST, 8'd253, 8'd127, 8'h00, 1'b0));
      send_random(40);
      // neutral at the bottom rail with full span: reverse saturates at zero
      apply_settings(1, 32767, 0, 1, 65534, 1, 65534);
      send_command(make_command(OP_THRUST, 8'd0, 8'd127, 8'h00, 1'b0));
      send_random(40);
      repeat (3) begin
         apply_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom);
         send_random(40);
      end
      apply_settings(DEADBAND_RST, HALF_SPAN_RST, NEUTRAL_RST, REST_RST, ACTIVE_RST,
                     PAIRED_RST, UNPAIRED_RST);
   endtask

   // Bulk random traffic under three idling patterns
   task automatic test_random_traffic();
      send_idle_pct = 8;
      recv_idle_pct = 66;
      send_random(500);
      send_idle_pct = 66;
      recv_idle_pct = 8;
      send_random(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(500);
   endtask

   // Output held off for a long stretch while commands keep coming: the pipe must fill and stall
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_seq++;
      send_random(40);
   endtask

   // Sender goes quiet until every result is back, then resumes
   task automatic test_sender_pause();
      send_idle_pct = 8;
      recv_idle_pct = 30;
      send_random(30);
      stop_commands();
      send_random(30);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 8;
      recv_idle_pct = 66;
      test_reset_values();
      test_directed_cases();
      test_register_settings();
      test_random_traffic();
      test_output_stall();
      test_sender_pause();
      stop_commands();
      $display("Ran %0d commands and checked %0d setpoint transactions", commands_sent,
               results_seen);
      $display("Register writes: %0d across %0d settings, with long output stall and pause",
               register_writes, settings_used);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5ms;
      $error("timeout: %0d setpoint transactions still pending", pending_setpoints.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
